### rtl/qbp_pkg.sv
`timescale 1ns / 1ps

package qbp_pkg;

  localparam int unsigned BYTE_BITS = 8;
  localparam logic [7:0] PIX_MASK = 8'hFF;

  // Register indexes on the configuration port
  localparam logic REG_BITS_PER_PIXEL = 1'b0;
  localparam logic REG_INVERT_PIXELS  = 1'b1;

  localparam logic [3:0] BPP_RESET  = 4'd8;
  localparam logic [3:0] FREE_RESET = 4'd8;

  typedef struct packed {
    logic [3:0] bits_per_pixel;
    logic       invert_pixels;
  } cfg_t;

  typedef struct packed {
    logic [7:0] packed_byte;
    logic       last_byte;
  } out_item_t;

  // Zero acts as one, anything above eight acts as eight
  function automatic logic [3:0] code_width(input logic [3:0] bpp);
    logic [3:0] q;
    begin
      if (bpp == 4'd0) begin
        q = 4'd1;
      end else if (bpp > 4'd8) begin
        q = 4'd8;
      end else begin
        q = bpp;
      end
      return q;
    end
  endfunction

endpackage

### rtl/qbp_regs.sv
`timescale 1ns / 1ps

module qbp_regs
  import qbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  output cfg_t        cfg
);

  logic [3:0] bpp_r;
  logic       inv_r;
  logic       reg_idx;
  logic       wr_en;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[2];
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r <= BPP_RESET;
      inv_r <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_BITS_PER_PIXEL: bpp_r <= cfg_pwdata[3:0];
        REG_INVERT_PIXELS:  inv_r <= cfg_pwdata[0];
        default:            ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BITS_PER_PIXEL: cfg_prdata = {28'd0, bpp_r};
      REG_INVERT_PIXELS:  cfg_prdata = {31'd0, inv_r};
      default:            cfg_prdata = 32'd0;
    endcase
  end

  assign cfg.bits_per_pixel = bpp_r;
  assign cfg.invert_pixels  = inv_r;

endmodule

### rtl/qbp_core.sv
`timescale 1ns / 1ps

module qbp_core
  import qbp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic [7:0] in_pixel,
  input  logic      in_last,
  input  logic      res_room,
  output logic      res_push,
  output out_item_t res_item
);

  logic       hold_r;
  logic [7:0] pix_r;
  logic       last_r;
  logic       pending_r;
  logic       pending_nxt;
  logic [7:0] partial_byte_r;
  logic [7:0] partial_byte_nxt;
  logic [3:0] free_bits_r;
  logic [3:0] free_bits_nxt;

  logic [3:0] q;
  logic [3:0] fb;
  logic [7:0] pix;
  logic [7:0] code;
  logic [3:0] over;
  logic [3:0] fb_p;
  logic [7:0] acc_p;
  logic       byte_done;
  logic [7:0] byte_val;
  logic       flush;
  logic       advance;
  logic       consume;

  assign q   = code_width(cfg.bits_per_pixel);
  assign fb  = (free_bits_r == 4'd0 || free_bits_r > 4'd8) ? FREE_RESET : free_bits_r;
  assign pix = pix_r ^ {8{cfg.invert_pixels}};
  assign code = pix >> (4'd8 - q);
  assign over = q - fb;

  // Place the code into the partial byte; a straddling code spills its low bits
  always_comb begin
    byte_done = 1'b0;
    byte_val  = partial_byte_r;
    fb_p      = fb;
    acc_p     = partial_byte_r;
    if (q <= fb) begin
      fb_p  = fb - q;
      acc_p = (partial_byte_r | (code << fb_p)) & PIX_MASK;
      if (fb_p == 4'd0) begin
        byte_done = 1'b1;
        byte_val  = acc_p;
        acc_p     = 8'd0;
        fb_p      = FREE_RESET;
      end
    end else begin
      byte_done = 1'b1;
      byte_val  = partial_byte_r | (code >> over);
      fb_p      = 4'd8 - over;
      acc_p     = (code << fb_p) & PIX_MASK;
    end
  end

  assign flush   = last_r && (fb_p < FREE_RESET);
  assign advance = hold_r && res_room;
  // A last pixel that completes a byte and leaves a remainder is held until its pad byte is pushed
  assign consume = advance && (pending_r || !(byte_done && flush));
  assign in_ready = !hold_r || consume;

  always_comb begin
    res_push         = 1'b0;
    res_item         = '0;
    pending_nxt      = pending_r;
    partial_byte_nxt = partial_byte_r;
    free_bits_nxt    = free_bits_r;
    if (advance) begin
      if (pending_r) begin
        res_push         = 1'b1;
        res_item         = '{packed_byte: partial_byte_r, last_byte: 1'b1};
        pending_nxt      = 1'b0;
        partial_byte_nxt = 8'd0;
        free_bits_nxt    = FREE_RESET;
      end else if (byte_done && flush) begin
        res_push         = 1'b1;
        res_item         = '{packed_byte: byte_val, last_byte: 1'b0};
        pending_nxt      = 1'b1;
        partial_byte_nxt = acc_p;
        free_bits_nxt    = fb_p;
      end else begin
        res_push = byte_done || flush;
        if (byte_done) begin
          res_item = '{packed_byte: byte_val, last_byte: last_r};
        end else begin
          res_item = '{packed_byte: acc_p, last_byte: 1'b1};
        end
        partial_byte_nxt = last_r ? 8'd0 : acc_p;
        free_bits_nxt    = last_r ? FREE_RESET : fb_p;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r         <= 1'b0;
      pending_r      <= 1'b0;
      partial_byte_r <= 8'd0;
      free_bits_r    <= FREE_RESET;
    end else begin
      hold_r         <= (hold_r && !consume) || (in_valid && in_ready);
      pending_r      <= pending_nxt;
      partial_byte_r <= partial_byte_nxt;
      free_bits_r    <= free_bits_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pix_r  <= in_pixel;
      last_r <= in_last;
    end
  end

`ifndef SYNTHESIS
  a_pending_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r |-> hold_r)
    else $error("flush pending without a held pixel");

  a_free_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
    (free_bits_r >= 4'd1) && (free_bits_r <= 4'd8))
    else $error("free bit count out of range");

  a_pending_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (pending_r && res_room) |=> !pending_r)
    else $error("pending flush not emitted");

  a_last_resets_state: assert property (@(posedge clk) disable iff (!rst_n)
    (consume && last_r) |=> (free_bits_r == FREE_RESET) && (partial_byte_r == 8'd0))
    else $error("packing state not cleared after last pixel");
`endif

endmodule

### rtl/qbp_outreg.sv
`timescale 1ns / 1ps

module qbp_outreg
  import qbp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      res_push,
  input  out_item_t res_item,
  output logic      res_room,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic      valid_r;
  out_item_t item_r;

  assign res_room  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_room) begin
      valid_r <= res_push;
    end
  end

  always_ff @(posedge clk) begin
    if (res_room && res_push) begin
      item_r <= res_item;
    end
  end

`ifndef SYNTHESIS
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !out_ready) |=> valid_r && $stable(item_r))
    else $error("stalled byte changed");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !res_room |-> valid_r)
    else $error("room lost with empty output");

  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (res_room && res_push) |=> valid_r)
    else $error("pushed byte not presented");
`endif

endmodule

### rtl/quantizing_bit_packer.sv
`timescale 1ns / 1ps

// Quantizing bit packer. Each pixel (in_tdata) is optionally inverted, cut to
// its top bits_per_pixel bits and packed MSB-first into bytes on out_tdata;
// codes may straddle bytes. A pixel with in_tlast flushes any partial byte,
// zero-padded, and the final byte carries out_tlast. A pixel passes an input
// register, the packing logic and an output register before its byte shows on
// out_tdata. One pixel is taken per cycle unless out_tready stalls, except
// that a last pixel which both completes a byte and leaves a remainder holds
// the packing stage until its pad byte is pushed; the output register moves
// one byte a cycle. Configuration writes go through the APB port; the user
// must make them only while no pixel is in flight; the block does not check.
// Register 0 (address 0) is bits_per_pixel, register 1 (address 4) is invert_pixels.

module quantizing_bit_packer
  import qbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] pixel_value
  input  logic        in_tlast,   // last_pixel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] packed_byte
  output logic        out_tlast,  // last_byte
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_t      cfg;
  logic      res_room;
  logic      res_push;
  out_item_t res_item;
  out_item_t out_item;

  qbp_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  qbp_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_pixel (in_tdata),
    .in_last  (in_tlast),
    .res_room (res_room),
    .res_push (res_push),
    .res_item (res_item)
  );

  qbp_outreg u_outreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_push  (res_push),
    .res_item  (res_item),
    .res_room  (res_room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (out_item)
  );

  assign out_tdata = out_item.packed_byte;
  assign out_tlast = out_item.last_byte;

endmodule

### test/quantizing_bit_packer_tb.sv
`timescale 1ns / 1ps

module quantizing_bit_packer_tb;
  import qbp_pkg::*;

  // One directed pixel with its settings; n_typed = 0 means the packing model
  // below supplies the expected bytes.
  typedef struct packed {
    logic [3:0] bpp;
    logic       inv;
    logic [7:0] pix;
    logic       is_last;
    logic [1:0] n_typed;
    logic [7:0] byte0;
    logic       last0;
    logic [7:0] byte1;
    logic       last1;
  } pix_row_t;

  localparam int N_DIR = 22;
  localparam pix_row_t DIR_ROWS [N_DIR] = '{
    '{4'd8,  1'b0, 8'hA5, 1'b0, 2'd1, 8'hA5, 1'b0, 8'h00, 1'b0},
    '{4'd8,  1'b0, 8'hFF, 1'b1, 2'd1, 8'hFF, 1'b1, 8'h00, 1'b0},
    '{4'd8,  1'b0, 8'h00, 1'b1, 2'd1, 8'h00, 1'b1, 8'h00, 1'b0},
    // width zero acts as one bit
    '{4'd0,  1'b0, 8'h80, 1'b1, 2'd1, 8'h80, 1'b1, 8'h00, 1'b0},
    // widths above eight act as eight
    '{4'd15, 1'b0, 8'h3C, 1'b1, 2'd1, 8'h3C, 1'b1, 8'h00, 1'b0},
    '{4'd9,  1'b1, 8'h00, 1'b1, 2'd1, 8'hFF, 1'b1, 8'h00, 1'b0},
    '{4'd8,  1'b1, 8'h12, 1'b0, 2'd1, 8'hED, 1'b0, 8'h00, 1'b0},
    '{4'd8,  1'b1, 8'hFF, 1'b1, 2'd1, 8'h00, 1'b1, 8'h00, 1'b0},
    // 3-bit codes straddle; last pixel completes a byte and leaves a remainder
    '{4'd3,  1'b0, 8'hE0, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{4'd3,  1'b0, 8'hFF, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{4'd3,  1'b0, 8'hFF, 1'b1, 2'd2, 8'hFF, 1'b0, 8'h80, 1'b1},
    '{4'd5,  1'b0, 8'hF8, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{4'd5,  1'b0, 8'h08, 1'b1, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
    // last pixel lands on a byte boundary: no pad byte
    '{4'd4,  1'b0, 8'hA0, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{4'd4,  1'b0, 8'h50, 1'b1, 2'd1, 8'hA5, 1'b1, 8'h00, 1'b0},
    // partial byte carried across settings changes
    '{4'd2,  1'b0, 8'hC0, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{4'd2,  1'b0, 8'h40, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{4'd7,  1'b1, 8'h5A, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{4'd7,  1'b1, 8'h01, 1'b1, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{4'd6,  1'b0, 8'hFF, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{4'd1,  1'b0, 8'hFF, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{4'd1,  1'b0, 8'h7F, 1'b1, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] pixel_value
  logic        in_tlast = 1'b0;    // last_pixel
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;          // [7:0] packed_byte
  logic        out_tlast;          // last_byte
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = 3'd0;
  logic [31:0] cfg_pwdata = 32'd0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Packing model state and settings
  logic [3:0]  bpp_reg = BPP_RESET;
  logic        inv_reg = 1'b0;
  logic [7:0]  acc_byte = 8'h00;
  int unsigned free_cnt = 8;

  out_item_t   pending_bytes[$];
  int unsigned err_cnt = 0;
  int unsigned burst_left = 0;
  int unsigned hold_request = 0;

  quantizing_bit_packer DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #2 clk = ~clk;

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  // Packs one pixel into the running byte; returns how many bytes it completes.
  function automatic int pack_pixel(input logic [7:0] pix, input logic is_last,
                                    output out_item_t r0, output out_item_t r1);
    int unsigned q;
    int unsigned fb;
    int unsigned over;
    int          n;
    logic [7:0]  val;
    logic [7:0]  code;
    logic [15:0] acc;
    out_item_t   res [2];
    res[0] = '0;
    res[1] = '0;
    n = 0;
    q = (bpp_reg == 4'd0) ? 1 : (bpp_reg > 4'd8) ? 8 : int'(bpp_reg);
    fb = free_cnt;
    acc = {8'h00, acc_byte};
    val = inv_reg ? 8'hFF - pix : pix;
    code = val >> (8 - q);
    if (q <= fb) begin
      fb = fb - q;
      acc = (acc | (16'(code) << fb)) & 16'h00FF;
      if (fb == 0) begin
        res[n] = '{acc[7:0], 1'b0};
        n++;
        acc = '0;
        fb = 8;
      end
    end else begin
      // high bits close the current byte, low bits open the next
      over = q - fb;
      res[n] = '{acc[7:0] | (code >> over), 1'b0};
      n++;
      fb = 8 - over;
      acc = (16'(code) << fb) & 16'h00FF;
    end
    if (is_last) begin
      if (fb < 8) begin
        res[n] = '{acc[7:0], 1'b0};
        n++;
      end
      if (n > 0) res[n - 1].last_byte = 1'b1;
      acc = '0;
      fb = 8;
    end
    acc_byte = acc[7:0];
    free_cnt = fb;
    r0 = res[0];
    r1 = res[1];
    return n;
  endfunction

  task automatic send_pixel(input pix_row_t row);
    int        n;
    int        gap;
    out_item_t r0;
    out_item_t r1;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= row.pix;
    in_tlast <= row.is_last;
    do @(posedge clk); while (!in_tready);
    n = pack_pixel(row.pix, row.is_last, r0, r1);
    if (row.n_typed != 2'd0) begin
      n = row.n_typed;
      r0 = '{row.byte0, row.last0};
      r1 = '{row.byte1, row.last1};
    end
    if (n > 0) pending_bytes.push_back(r0);
    if (n > 1) pending_bytes.push_back(r1);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // Stop offering and let every outstanding byte come out
  task automatic drain_bytes();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [3:0] value);
    logic [31:0] data;
    data = $urandom();
    if (idx == REG_BITS_PER_PIXEL) data[3:0] = value;
    else data[0] = value[0];
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (idx == REG_BITS_PER_PIXEL) bpp_reg = data[3:0];
    else inv_reg = data[0];
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic set_config(input logic [3:0] bpp, input logic inv);
    drain_bytes();
    if ($urandom_range(0, 1)) begin
      write_reg(REG_BITS_PER_PIXEL, bpp);
      write_reg(REG_INVERT_PIXELS, {3'b000, inv});
    end else begin
      write_reg(REG_INVERT_PIXELS, {3'b000, inv});
      write_reg(REG_BITS_PER_PIXEL, bpp);
    end
  endtask

  // Receiver: changing stall pattern, plus long hold-offs on request
  int unsigned rx_cycle = 0;
  int unsigned rx_mode = 0;
  int unsigned hold_left = 0;
  int unsigned holds_served = 0;

  always @(negedge clk) begin
    rx_cycle++;
    if (rx_cycle % 200 == 0) rx_mode = $urandom_range(0, 4);
    if (hold_request != holds_served) begin
      holds_served = hold_request;
      hold_left = 80;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        2: out_tready <= ((rx_cycle % 7) > 1);
        3: out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= rx_cycle[2];
      endcase
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_bytes.size() == 0) begin
        if (err_cnt < 100)
          $display("%0t: unexpected byte, expected none, got %02h last %0b",
                   $time, out_tdata, out_tlast);
        err_cnt++;
      end else begin
        want = pending_bytes.pop_front();
        if (out_tdata !== want.packed_byte) begin
          if (err_cnt < 100)
            $display("%0t: packed_byte mismatch, expected %02h, got %02h",
                     $time, want.packed_byte, out_tdata);
          err_cnt++;
        end
        if (out_tlast !== want.last_byte) begin
          if (err_cnt < 100)
            $display("%0t: last_byte mismatch, expected %0b, got %0b",
                     $time, want.last_byte, out_tlast);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    pix_row_t    row;
    int unsigned sent;
    int unsigned phase;
    int unsigned n_img;
    int unsigned img_len;
    logic [3:0]  bpp_pick;
    logic        inv_pick;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIR; i++) begin
      if (DIR_ROWS[i].bpp != bpp_reg || DIR_ROWS[i].inv != inv_reg)
        set_config(DIR_ROWS[i].bpp, DIR_ROWS[i].inv);
      send_pixel(DIR_ROWS[i]);
    end

    sent = 0;
    phase = 0;
    while (sent < 1400) begin
      case (phase)
        0: bpp_pick = 4'd1;
        1: bpp_pick = 4'd8;
        2: bpp_pick = 4'd0;
        3: bpp_pick = 4'd15;
        default: bpp_pick = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15))
                                                         : 4'($urandom_range(1, 8));
      endcase
      inv_pick = (phase < 4) ? phase[0] : 1'($urandom_range(0, 1));
      set_config(bpp_pick, inv_pick);
      // receiver holds off while a long burst keeps coming
      if (phase == 2 || phase == 9) begin
        hold_request++;
        burst_left = 200;
      end
      n_img = $urandom_range(2, 8);
      for (int m = 0; m < n_img; m++) begin
        img_len = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 20);
        for (int k = 0; k < img_len; k++) begin
          row = '0;
          row.pix = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                                : 8'($urandom_range(0, 255));
          row.is_last = (k == img_len - 1);
          send_pixel(row);
          sent++;
        end
      end
      // sometimes leave an image open across the next settings change
      if ($urandom_range(0, 3) == 0) begin
        img_len = $urandom_range(1, 5);
        for (int k = 0; k < img_len; k++) begin
          row = '0;
          row.pix = 8'($urandom_range(0, 255));
          send_pixel(row);
          sent++;
        end
      end
      phase++;
    end

    drain_bytes();
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
